// ----- hdl/polyline_slice_area_accumulator_unit_defines.svh -----
// assertion macros for the polyline slice area accumulator
`ifndef POLYLINE_SLICE_AREA_ACCUMULATOR_UNIT_DEFINES_SVH
`define POLYLINE_SLICE_AREA_ACCUMULATOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define PSAA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same cycle implication");
`define PSAA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next cycle implication");
`else
`define PSAA_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define PSAA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- hdl/psaa_pkg.sv -----
`default_nettype none
package psaa_pkg;

  localparam int COORD_BITS = 24;
  localparam int FRAC_BITS  = 16;
  localparam int SUM_BITS   = 40;
  localparam int RAD_BITS   = 2 * COORD_BITS;
  localparam int ROOT_BITS  = COORD_BITS;
  localparam int REM_BITS   = ROOT_BITS + 1;
  localparam int PROD_BITS  = 2 * COORD_BITS;
  localparam int CNT_BITS   = $clog2(ROOT_BITS);
  localparam int TERM_SHIFT = FRAC_BITS + 1;

  localparam int APB_DATA_BITS = 32;
  localparam int PADDR_BITS    = 3;
  localparam int REG_IDX_BITS  = PADDR_BITS - 2;

  localparam logic [REG_IDX_BITS-1:0] REG_PEAK_HEIGHT = '0;
  localparam logic signed [COORD_BITS-1:0] PEAK_RESET = COORD_BITS'(6553600);
  localparam logic [SUM_BITS-1:0] SUM_MAX = '1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQX,
    ST_SQZ,
    ST_SUM,
    ST_ROOT,
    ST_MUL,
    ST_ACC,
    ST_EMIT
  } psaa_state_t;

  function automatic logic [COORD_BITS-1:0] mag(input logic [COORD_BITS-1:0] v);
    mag = v[COORD_BITS-1] ? (~v + COORD_BITS'(1)) : v;
  endfunction

  function automatic logic [COORD_BITS-1:0] absdiff(input logic [COORD_BITS-1:0] a,
                                                    input logic [COORD_BITS-1:0] b);
    absdiff = (a > b) ? (a - b) : (b - a);
  endfunction

endpackage
`default_nettype wire

// ----- hdl/psaa_in_if.sv -----
`default_nettype none
interface psaa_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [psaa_pkg::COORD_BITS-1:0] coord_x;
  logic signed [psaa_pkg::COORD_BITS-1:0] coord_y;
  logic signed [psaa_pkg::COORD_BITS-1:0] coord_z;
  logic                                last_point;

  modport source (output valid, coord_x, coord_y, coord_z, last_point, input ready);
  modport sink (input valid, coord_x, coord_y, coord_z, last_point, output ready);
endinterface
`default_nettype wire

// ----- hdl/psaa_out_if.sv -----
`default_nettype none
interface psaa_out_if;
  logic                            valid;
  logic                            ready;
  logic [psaa_pkg::SUM_BITS-1:0]   area_total;
  logic                            area_saturated;

  modport source (output valid, area_total, area_saturated, input ready);
  modport sink (input valid, area_total, area_saturated, output ready);
endinterface
`default_nettype wire

// ----- hdl/psaa_isqrt.sv -----
`default_nettype none
module psaa_isqrt (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  input  wire logic [psaa_pkg::RAD_BITS-1:0]     rad,
  output logic                                   done,
  output logic      [psaa_pkg::ROOT_BITS-1:0]    root
);

  logic                              busy_r;
  logic [psaa_pkg::CNT_BITS-1:0]     cnt_r;
  logic [psaa_pkg::RAD_BITS-1:0]     rad_r;
  logic [psaa_pkg::REM_BITS-1:0]     rem_r;
  logic [psaa_pkg::ROOT_BITS-1:0]    root_r;

  logic [psaa_pkg::REM_BITS+1:0]     rem_sh;
  logic [psaa_pkg::REM_BITS+1:0]     trial;
  logic                              fits;

  // two radicand bits per step, restoring
  always_comb begin
    rem_sh = {rem_r, rad_r[psaa_pkg::RAD_BITS-1 -: 2]};
    trial  = (psaa_pkg::REM_BITS+2)'({root_r, 2'b01});
    fits   = (rem_sh >= trial);
  end

  assign done = busy_r && (cnt_r == psaa_pkg::CNT_BITS'(psaa_pkg::ROOT_BITS - 1));
  assign root = root_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      busy_r <= !done;
      cnt_r  <= cnt_r + psaa_pkg::CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= rad;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r <= {rad_r[psaa_pkg::RAD_BITS-3:0], 2'b00};
      if (fits) begin
        rem_r  <= psaa_pkg::REM_BITS'(rem_sh - trial);
        root_r <= {root_r[psaa_pkg::ROOT_BITS-2:0], 1'b1};
      end else begin
        rem_r  <= psaa_pkg::REM_BITS'(rem_sh);
        root_r <= {root_r[psaa_pkg::ROOT_BITS-2:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

// ----- hdl/polyline_slice_area_accumulator_unit.sv -----
// a point that closes a counted pair steps through SQX, SQZ, SUM, ROOT, MUL and ACC,
// then EMIT when it is marked last, before the next transfer; its result is loaded in EMIT
// a point that forms no pair stays in IDLE, or goes through EMIT when marked last
// the 24-step digit-serial square root (two radicand bits a cycle) sets the rate,
// and a result still held by the receiver stalls the next result load
// reset: synchronous active-low rst_n clears the run and result, peak_height to 100.0
`default_nettype none
`include "polyline_slice_area_accumulator_unit_defines.svh"
module polyline_slice_area_accumulator_unit (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  psaa_in_if.sink                                     in_chan,
  psaa_out_if.source                                  out_chan,
  input  wire logic                                   psel,
  input  wire logic                                   penable,
  input  wire logic                                   pwrite,
  input  wire logic [psaa_pkg::PADDR_BITS-1:0]        paddr,
  input  wire logic [psaa_pkg::APB_DATA_BITS-1:0]     pwdata,
  output logic      [psaa_pkg::APB_DATA_BITS-1:0]     prdata,
  output logic                                        pready
);

  localparam int CB = psaa_pkg::COORD_BITS;

  psaa_pkg::psaa_state_t state_r, state_nxt;

  logic signed [CB-1:0]              peak_r;
  logic [CB-1:0]                     prev_x_r, prev_y_r, prev_z_r;
  logic                              have_prev_r;
  logic [CB-1:0]                     dx_r, dz_r, dy_r;
  logic                              last_r;
  logic [psaa_pkg::PROD_BITS-1:0]    prod_r, sqa_r;
  logic [psaa_pkg::SUM_BITS-1:0]     sum_r;
  logic                              sat_r;
  logic                              out_valid_r;
  logic [psaa_pkg::SUM_BITS-1:0]     out_total_r;
  logic                              out_sat_r;

  logic                              accept;
  logic                              pair;
  logic [psaa_pkg::REG_IDX_BITS-1:0] reg_idx;
  logic                              cfg_wr;
  logic [CB-1:0]                     mul_a, mul_b;
  logic [psaa_pkg::PROD_BITS-1:0]    prod;
  logic                              sqrt_start;
  logic                              sqrt_done;
  logic [psaa_pkg::ROOT_BITS-1:0]    root;
  logic [psaa_pkg::PROD_BITS-1:0]    term;
  logic [psaa_pkg::SUM_BITS:0]       sum_ext;
  logic                              emit;

  // config port
  assign pready  = 1'b1;
  assign reg_idx = paddr[psaa_pkg::PADDR_BITS-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    prdata = '0;
    if (reg_idx == psaa_pkg::REG_PEAK_HEIGHT) begin
      prdata = psaa_pkg::APB_DATA_BITS'(peak_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_r <= psaa_pkg::PEAK_RESET;
    end else if (cfg_wr && reg_idx == psaa_pkg::REG_PEAK_HEIGHT) begin
      peak_r <= signed'(pwdata[CB-1:0]);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      psaa_pkg::ST_IDLE: begin
        if (in_chan.valid) begin
          if (pair) begin
            state_nxt = psaa_pkg::ST_SQX;
          end else if (in_chan.last_point) begin
            state_nxt = psaa_pkg::ST_EMIT;
          end
        end
      end
      psaa_pkg::ST_SQX:  state_nxt = psaa_pkg::ST_SQZ;
      psaa_pkg::ST_SQZ:  state_nxt = psaa_pkg::ST_SUM;
      psaa_pkg::ST_SUM:  state_nxt = psaa_pkg::ST_ROOT;
      psaa_pkg::ST_ROOT: begin
        if (sqrt_done) begin
          state_nxt = psaa_pkg::ST_MUL;
        end
      end
      psaa_pkg::ST_MUL:  state_nxt = psaa_pkg::ST_ACC;
      psaa_pkg::ST_ACC:  state_nxt = last_r ? psaa_pkg::ST_EMIT : psaa_pkg::ST_IDLE;
      psaa_pkg::ST_EMIT: begin
        if (!out_valid_r || out_chan.ready) begin
          state_nxt = psaa_pkg::ST_IDLE;
        end
      end
      default: state_nxt = psaa_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_chan.ready = 1'b0;
    sqrt_start    = 1'b0;
    emit          = 1'b0;
    mul_a         = dx_r;
    mul_b         = dx_r;
    unique case (state_r)
      psaa_pkg::ST_IDLE: in_chan.ready = 1'b1;
      psaa_pkg::ST_SQZ: begin
        mul_a = dz_r;
        mul_b = dz_r;
      end
      psaa_pkg::ST_SUM:  sqrt_start = 1'b1;
      psaa_pkg::ST_MUL: begin
        mul_a = CB'(root);
        mul_b = dy_r;
      end
      psaa_pkg::ST_EMIT: emit = !out_valid_r || out_chan.ready;
      default: ;
    endcase
  end

  assign accept = in_chan.valid && in_chan.ready;
  assign pair   = have_prev_r && !(signed'(prev_y_r) > peak_r);
  assign prod   = psaa_pkg::PROD_BITS'(mul_a) * psaa_pkg::PROD_BITS'(mul_b);
  assign term   = prod_r >> psaa_pkg::TERM_SHIFT;
  assign sum_ext = (psaa_pkg::SUM_BITS+1)'(sum_r) + (psaa_pkg::SUM_BITS+1)'(term);

  psaa_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .rad   (sqa_r + prod_r),
    .done  (sqrt_done),
    .root  (root)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= psaa_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // point capture and differences
  always_ff @(posedge clk) begin
    if (accept) begin
      prev_x_r <= in_chan.coord_x;
      prev_y_r <= in_chan.coord_y;
      prev_z_r <= in_chan.coord_z;
      last_r   <= in_chan.last_point;
      dx_r     <= psaa_pkg::absdiff(psaa_pkg::mag(prev_x_r), psaa_pkg::mag(in_chan.coord_x));
      dz_r     <= psaa_pkg::absdiff(psaa_pkg::mag(prev_z_r), psaa_pkg::mag(in_chan.coord_z));
      dy_r     <= psaa_pkg::absdiff(psaa_pkg::mag(prev_y_r), psaa_pkg::mag(in_chan.coord_y));
    end
  end

  // shared multiplier
  always_ff @(posedge clk) begin
    if (state_r == psaa_pkg::ST_SQX || state_r == psaa_pkg::ST_SQZ ||
        state_r == psaa_pkg::ST_MUL) begin
      prod_r <= prod;
    end
    if (state_r == psaa_pkg::ST_SQZ) begin
      sqa_r <= prod_r;
    end
  end

  // run state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_prev_r <= 1'b0;
      sum_r       <= '0;
      sat_r       <= 1'b0;
    end else if (emit) begin
      have_prev_r <= 1'b0;
      sum_r       <= '0;
      sat_r       <= 1'b0;
    end else begin
      if (accept) begin
        have_prev_r <= 1'b1;
      end
      if (state_r == psaa_pkg::ST_ACC) begin
        if (sum_ext[psaa_pkg::SUM_BITS]) begin
          sum_r <= psaa_pkg::SUM_MAX;
          sat_r <= 1'b1;
        end else begin
          sum_r <= sum_ext[psaa_pkg::SUM_BITS-1:0];
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_total_r <= sum_r;
      out_sat_r   <= sat_r;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.area_total     = out_total_r;
  assign out_chan.area_saturated = out_sat_r;

  `PSAA_ASSERT_SAME(a_sat_clamped, clk, rst_n, sat_r, sum_r == psaa_pkg::SUM_MAX)
  `PSAA_ASSERT_SAME(a_root_in_wait, clk, rst_n, sqrt_done, state_r == psaa_pkg::ST_ROOT)
  `PSAA_ASSERT_NEXT(a_skip_short, clk, rst_n, accept && !pair,
                    state_r == psaa_pkg::ST_IDLE || state_r == psaa_pkg::ST_EMIT)
  `PSAA_ASSERT_NEXT(a_emit_clears, clk, rst_n, emit,
                    !have_prev_r && sum_r == '0 && out_valid_r)

endmodule
`default_nettype wire

// ----- tb/tb_polyline_slice_area_accumulator_unit.sv -----
`default_nettype none
module tb_polyline_slice_area_accumulator_unit;

  localparam int CB = psaa_pkg::COORD_BITS;
  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 40;
  localparam logic signed [CB-1:0] COORD_MIN = {1'b1, {(CB-1){1'b0}}};
  localparam logic signed [CB-1:0] COORD_MAX = {1'b0, {(CB-1){1'b1}}};

  typedef struct {
    logic [psaa_pkg::SUM_BITS-1:0] total;
    logic                          sat;
  } area_result_t;

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [psaa_pkg::PADDR_BITS-1:0] paddr;
  logic [psaa_pkg::APB_DATA_BITS-1:0] pwdata;
  logic [psaa_pkg::APB_DATA_BITS-1:0] prdata;
  logic pready;

  psaa_in_if  in_if();
  psaa_out_if out_if();

  polyline_slice_area_accumulator_unit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // predicted block state
  logic signed [CB-1:0]          pk_height;
  logic signed [CB-1:0]          last_x, last_y, last_z;
  logic                          have_last;
  logic [psaa_pkg::SUM_BITS-1:0] run_area;
  logic                          run_sat;
  area_result_t                  expected_areas[$];

  int fail_count;
  int points_sent;
  int areas_checked;
  int peak_writes;
  int sat_results;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_left;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [CB:0] mag_diff(input logic signed [CB-1:0] a,
                                           input logic signed [CB-1:0] b);
    logic signed [CB:0] ea, eb;
    logic [CB:0] ma, mb;
    ea = a;
    eb = b;
    ma = (ea < 0) ? -ea : ea;
    mb = (eb < 0) ? -eb : eb;
    return (ma > mb) ? ma - mb : mb - ma;
  endfunction

  function automatic logic [CB-1:0] floor_sqrt(input logic [2*CB-1:0] n);
    logic [2*CB+1:0] rem;
    logic [2*CB+1:0] trial;
    logic [CB-1:0]   root;
    rem = '0;
    root = '0;
    for (int i = CB - 1; i >= 0; i--) begin
      rem = {rem[2*CB-1:0], n[2*i +: 2]};
      trial = {root, 2'b01};
      if (rem >= trial) begin
        rem = rem - trial;
        root = {root[CB-2:0], 1'b1};
      end else begin
        root = {root[CB-2:0], 1'b0};
      end
    end
    return root;
  endfunction

  task automatic track_point(input logic signed [CB-1:0] x,
                             input logic signed [CB-1:0] y,
                             input logic signed [CB-1:0] z,
                             input logic last);
    logic [CB:0]     dx, dy, dz;
    logic [2*CB-1:0] radicand;
    logic [CB-1:0]   width;
    logic [63:0]     term;
    area_result_t    res;
    if (have_last && !(last_y > pk_height)) begin
      dx = mag_diff(last_x, x);
      dy = mag_diff(last_y, y);
      dz = mag_diff(last_z, z);
      radicand = (2*CB)'(dx) * (2*CB)'(dx) + (2*CB)'(dz) * (2*CB)'(dz);
      width = floor_sqrt(radicand);
      term = (64'(width) * 64'(dy)) >> psaa_pkg::TERM_SHIFT;
      if (term > 64'(psaa_pkg::SUM_MAX) - 64'(run_area)) begin
        run_area = psaa_pkg::SUM_MAX;
        run_sat = 1'b1;
      end else begin
        run_area = run_area + term[psaa_pkg::SUM_BITS-1:0];
      end
    end
    last_x = x;
    last_y = y;
    last_z = z;
    have_last = 1'b1;
    if (last) begin
      res.total = run_area;
      res.sat = run_sat;
      expected_areas.push_back(res);
      run_area = '0;
      run_sat = 1'b0;
      have_last = 1'b0;
    end
  endtask

  task automatic send_point(input logic signed [CB-1:0] x,
                            input logic signed [CB-1:0] y,
                            input logic signed [CB-1:0] z,
                            input logic last);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.valid = 1'b1;
    in_if.coord_x = x;
    in_if.coord_y = y;
    in_if.coord_z = z;
    in_if.last_point = last;
    do @(posedge clk); while (!in_if.ready);
    track_point(x, y, z, last);
    points_sent++;
  endtask

  // block idle: all results back plus room for a pair still in the datapath
  task automatic settle();
    @(negedge clk);
    in_if.valid = 1'b0;
    while (expected_areas.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_peak(input logic signed [CB-1:0] v);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {psaa_pkg::REG_PEAK_HEIGHT, 2'b00};
    pwdata = psaa_pkg::APB_DATA_BITS'(v);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    pk_height = v;
    peak_writes++;
    @(negedge clk);
    penable = 1'b0;
    pwrite = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[CB-1:0] !== v)
      $error("peak_height mismatch: expected %0h, actual %0h", v, prdata[CB-1:0]);
    if (prdata[CB-1:0] !== v) fail_count++;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  function automatic logic signed [CB-1:0] pick_coord();
    case ($urandom_range(9))
      0: return COORD_MIN;
      1: return COORD_MAX;
      2: return '0;
      3, 4, 5: return CB'($urandom);
      default: return CB'(int'($urandom_range(0, 2**21)) - 2**20);
    endcase
  endfunction

  function automatic logic signed [CB-1:0] pick_height();
    longint h;
    if ($urandom_range(3) != 0) return pick_coord();
    h = longint'(pk_height) + longint'($urandom_range(0, 4)) - 2;
    if (h > longint'(COORD_MAX)) h = longint'(COORD_MAX);
    if (h < longint'(COORD_MIN)) h = longint'(COORD_MIN);
    return CB'(h);
  endfunction

  task automatic send_random_run();
    int len;
    logic signed [CB-1:0] x, y, z;
    len = ($urandom_range(9) == 0) ? $urandom_range(12, 30) : $urandom_range(1, 6);
    for (int i = 0; i < len; i++) begin
      if (i == 0 || $urandom_range(15) != 0) begin
        x = pick_coord();
        y = pick_height();
        z = pick_coord();
      end
      send_point(x, y, z, i == len - 1);
    end
  endtask

  task automatic test_reset_peak();
    send_point('0, '0, '0, 1'b1);
    send_point(COORD_MIN, psaa_pkg::PEAK_RESET, COORD_MAX, 1'b0);
    send_point(COORD_MAX, COORD_MIN, '0, 1'b1);
    send_point(24'sd65536, psaa_pkg::PEAK_RESET + 24'sd1, -24'sd65536, 1'b0);
    send_point(-24'sd131072, '0, 24'sd131072, 1'b1);
  endtask

  task automatic test_directed();
    settle();
    write_peak('0);
    send_point(COORD_MIN, '0, COORD_MIN, 1'b0);
    send_point(COORD_MAX, COORD_MIN, '0, 1'b0);
    send_point('0, COORD_MAX, COORD_MAX, 1'b0);
    send_point(COORD_MIN, '0, COORD_MIN, 1'b0);
    send_point(-24'sd1, 24'sd1, 24'sd1, 1'b1);
    send_point(24'sd300000, -24'sd70000, 24'sd5, 1'b0);
    send_point(24'sd300000, -24'sd70000, 24'sd5, 1'b1);
    send_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
    settle();
    write_peak(COORD_MIN);
    send_point(COORD_MAX, COORD_MIN, COORD_MIN, 1'b0);
    send_point('0, '0, '0, 1'b0);
    send_point(COORD_MIN, COORD_MAX, COORD_MAX, 1'b1);
    send_point(24'sd4096, COORD_MIN, -24'sd4096, 1'b0);
    send_point(-24'sd8192, COORD_MIN + 24'sd1, 24'sd77, 1'b1);
  endtask

  task automatic test_random_phases();
    int phase_items;
    for (int phase = 0; phase < 4; phase++) begin
      settle();
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  write_peak(COORD_MAX); end
        1: begin send_idle_pct = 70; recv_stall_pct = 0;  write_peak(psaa_pkg::PEAK_RESET); end
        2: begin send_idle_pct = 0;  recv_stall_pct = 70; write_peak(COORD_MIN); end
        default: begin
          send_idle_pct = 38;
          recv_stall_pct = 38;
          write_peak(CB'($urandom));
        end
      endcase
      phase_items = points_sent + 150;
      while (points_sent < phase_items) begin
        send_random_run();
      end
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  task automatic test_backpressure();
    settle();
    write_peak('0);
    @(posedge clk);
    hold_left = 400;
    for (int i = 0; i < 20; i++) begin
      send_point(pick_coord(), pick_height(), pick_coord(), i % 3 != 0);
    end
    send_point(pick_coord(), pick_height(), pick_coord(), 1'b1);
  endtask

  // large alternating pairs give the largest terms
  task automatic test_large_terms();
    settle();
    write_peak(COORD_MAX);
    for (int i = 0; i < 120; i++) begin
      if (i % 2 == 0)
        send_point('0, '0, '0, 1'b0);
      else
        send_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
    end
    send_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
    send_point(24'sd1000, -24'sd2000, 24'sd3000, 1'b0);
    send_point(-24'sd4000, 24'sd5000, -24'sd6000, 1'b1);
  endtask

  // result checker
  initial begin
    area_result_t exp_res;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready) begin
        areas_checked++;
        if (expected_areas.size() == 0) begin
          $error("area_total unexpected: expected none, actual %0h", out_if.area_total);
          fail_count++;
        end else begin
          exp_res = expected_areas.pop_front();
          if (exp_res.sat) sat_results++;
          if (out_if.area_total !== exp_res.total) begin
            $error("area_total mismatch: expected %0h, actual %0h",
                   exp_res.total, out_if.area_total);
            fail_count++;
          end
          if (out_if.area_saturated !== exp_res.sat) begin
            $error("area_saturated mismatch: expected %0b, actual %0b",
                   exp_res.sat, out_if.area_saturated);
            fail_count++;
          end
        end
      end
    end
  end

  // receiver with random stalls and a long hold-off on request
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_if.ready = 1'b0;
        hold_left--;
      end else begin
        out_if.ready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // watchdog on cycles with no transfer at all
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (psel && penable && pready))
        quiet = 0;
      else
        quiet++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_if.valid = 1'b0;
    in_if.coord_x = '0;
    in_if.coord_y = '0;
    in_if.coord_z = '0;
    in_if.last_point = 1'b0;
    pk_height = psaa_pkg::PEAK_RESET;
    last_x = '0;
    last_y = '0;
    last_z = '0;
    have_last = 1'b0;
    run_area = '0;
    run_sat = 1'b0;
    fail_count = 0;
    points_sent = 0;
    areas_checked = 0;
    peak_writes = 0;
    sat_results = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_left = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_peak();
    test_directed();
    test_random_phases();
    test_backpressure();
    test_large_terms();
    settle();

    $display("covered %0d points and %0d area results (%0d clamped)",
             points_sent, areas_checked, sat_results);
    $display("peak height written %0d times, idle and stall phases plus one long hold-off",
             peak_writes);
    if (fail_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
`default_nettype wire

// ----- sim.f -----
+incdir+hdl
hdl/psaa_pkg.sv
hdl/psaa_in_if.sv
hdl/psaa_out_if.sv
hdl/psaa_isqrt.sv
hdl/polyline_slice_area_accumulator_unit.sv
tb/tb_polyline_slice_area_accumulator_unit.sv
